>>> hw/rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared constants, widths and controller/datapath command and status types
// for the topological sort unit.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;
  localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_CW  = $clog2(MAX_EDGES + 1);
  localparam int DEG_W    = EDGE_CW;
  localparam int QUEUE_AW = $clog2(MAX_VERTICES);
  localparam int QUEUE_CW = $clog2(MAX_VERTICES + 1);

  localparam logic [0:0] CMD_LOAD  = 1'b0;
  localparam logic [0:0] CMD_START = 1'b1;

  typedef struct packed {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
  } edge_t;

  typedef struct packed {
    logic load_edge;
    logic i_clr;
    logic i_inc;
    logic e_clr;
    logic e_inc;
    logic queue_clr;
    logic deg_zero_wr;
    logic edge_rd;
    logic deg_rd_dst;
    logic deg_inc_wr;
    logic deg_rd_i;
    logic queue_push_i;
    logic queue_rd_head;
    logic u_load;
    logic deg_dec;
    logic total_clr;
    logic queue_rd_i;
    logic out_load_order;
    logic out_load_cycle;
  } dp_cmd_t;

  typedef struct packed {
    logic i_lt_n;
    logic i_last;
    logic e_lt_total;
    logic edge_ok;
    logic edge_match;
    logic head_lt_tail;
    logic tail_eq_n;
    logic n_zero;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/kts_if.sv
// ----------------------------------------------------------------------------
// kts_if
// Valid/ready channel interfaces: request items, result items and the
// vertex count write port.
// ----------------------------------------------------------------------------
interface kts_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [kts_pkg::VERTEX_W-1:0]  edge_source;
  logic [kts_pkg::VERTEX_W-1:0]  edge_dest;

  modport source (output valid, output cmd, output edge_source, output edge_dest,
                  input ready);
  modport sink (input valid, input cmd, input edge_source, input edge_dest,
                output ready);
endinterface

interface kts_res_if;
  logic                          valid;
  logic                          ready;
  logic [kts_pkg::VERTEX_W-1:0]  vertex;
  logic                          last;
  logic                          has_cycle;

  modport source (output valid, output vertex, output last, output has_cycle,
                  input ready);
  modport sink (input valid, input vertex, input last, input has_cycle,
                output ready);
endinterface

interface kts_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kts_pkg::COUNT_W-1:0]   vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink (input valid, input vertex_count, output ready);
endinterface

>>> hw/rtl/kts_dp.sv
// ----------------------------------------------------------------------------
// kts_dp
// Datapath: edge store, in-degree and ready-queue memories, counters,
// vertex count register and the result output register.
// ----------------------------------------------------------------------------
module kts_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kts_pkg::dp_cmd_t              cmd,
  output kts_pkg::dp_status_t           status,
  input  logic                          cfg_we,
  input  logic [kts_pkg::COUNT_W-1:0]   cfg_data,
  input  logic [kts_pkg::VERTEX_W-1:0]  edge_source,
  input  logic [kts_pkg::VERTEX_W-1:0]  edge_dest,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kts_pkg::VERTEX_W-1:0]  vertex,
  output logic                          last,
  output logic                          has_cycle
);

  logic [kts_pkg::COUNT_W-1:0]   vertex_count;
  logic [kts_pkg::COUNT_W-1:0]   n;
  logic [kts_pkg::EDGE_CW-1:0]   total;
  logic [kts_pkg::EDGE_CW-1:0]   e;
  logic [kts_pkg::COUNT_W-1:0]   i;
  logic [kts_pkg::QUEUE_CW-1:0]  head;
  logic [kts_pkg::QUEUE_CW-1:0]  tail;
  logic [kts_pkg::VERTEX_W-1:0]  u;

  kts_pkg::edge_t                edge_mem [kts_pkg::MAX_EDGES];
  kts_pkg::edge_t                edge_q;
  logic [kts_pkg::DEG_W-1:0]     deg_mem [kts_pkg::MAX_VERTICES];
  logic [kts_pkg::DEG_W-1:0]     deg_q;
  logic [kts_pkg::VERTEX_W-1:0]  queue_mem [kts_pkg::MAX_VERTICES];
  logic [kts_pkg::VERTEX_W-1:0]  queue_q;

  logic                          load_ok;
  logic                          push_dec;
  logic                          deg_we;
  logic [kts_pkg::QUEUE_AW-1:0]  deg_wa;
  logic [kts_pkg::QUEUE_AW-1:0]  deg_ra;
  logic [kts_pkg::DEG_W-1:0]     deg_wd;
  logic                          queue_we;
  logic [kts_pkg::VERTEX_W-1:0]  queue_wd;
  logic [kts_pkg::QUEUE_AW-1:0]  queue_ra;
  logic                          edge_dst_in;

  assign n = (vertex_count > kts_pkg::COUNT_W'(kts_pkg::MAX_VERTICES)) ?
             kts_pkg::COUNT_W'(kts_pkg::MAX_VERTICES) : vertex_count;

  assign load_ok = (kts_pkg::COUNT_W'(edge_source) < n) &&
                   (kts_pkg::COUNT_W'(edge_dest) < n) &&
                   (total < kts_pkg::EDGE_CW'(kts_pkg::MAX_EDGES));

  assign edge_dst_in = kts_pkg::COUNT_W'(edge_q.dst) < n;
  assign push_dec = cmd.deg_dec && (deg_q == kts_pkg::DEG_W'(1)) &&
                    (tail < kts_pkg::QUEUE_CW'(kts_pkg::MAX_VERTICES));

  always_comb begin
    deg_we = cmd.deg_zero_wr || cmd.deg_inc_wr ||
             (cmd.deg_dec && (deg_q != '0));
    deg_wa = cmd.deg_zero_wr ? i[kts_pkg::QUEUE_AW-1:0] :
             kts_pkg::QUEUE_AW'(edge_q.dst);
    deg_wd = '0;
    if (cmd.deg_inc_wr) begin
      deg_wd = deg_q + kts_pkg::DEG_W'(1);
    end else if (cmd.deg_dec) begin
      deg_wd = deg_q - kts_pkg::DEG_W'(1);
    end
    deg_ra = cmd.deg_rd_dst ? kts_pkg::QUEUE_AW'(edge_q.dst) : i[kts_pkg::QUEUE_AW-1:0];
    queue_we = (cmd.queue_push_i && (deg_q == '0)) || push_dec;
    queue_wd = cmd.queue_push_i ? i[kts_pkg::VERTEX_W-1:0] : edge_q.dst;
    queue_ra = cmd.queue_rd_head ? head[kts_pkg::QUEUE_AW-1:0] : i[kts_pkg::QUEUE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && load_ok) begin
      edge_mem[total[kts_pkg::EDGE_AW-1:0]] <= '{src: edge_source, dst: edge_dest};
    end
    if (cmd.edge_rd) begin
      edge_q <= edge_mem[e[kts_pkg::EDGE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (cmd.deg_rd_dst || cmd.deg_rd_i) begin
      deg_q <= deg_mem[deg_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[tail[kts_pkg::QUEUE_AW-1:0]] <= queue_wd;
    end
    if (cmd.queue_rd_head || cmd.queue_rd_i) begin
      queue_q <= queue_mem[queue_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= kts_pkg::COUNT_W'(1);
      total        <= '0;
      e            <= '0;
      i            <= '0;
      head         <= '0;
      tail         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (cmd.total_clr) begin
        total <= '0;
      end else if (cmd.load_edge && load_ok) begin
        total <= total + kts_pkg::EDGE_CW'(1);
      end
      if (cmd.e_clr) begin
        e <= '0;
      end else if (cmd.e_inc) begin
        e <= e + kts_pkg::EDGE_CW'(1);
      end
      if (cmd.i_clr) begin
        i <= '0;
      end else if (cmd.i_inc) begin
        i <= i + kts_pkg::COUNT_W'(1);
      end
      if (cmd.queue_clr) begin
        head <= '0;
      end else if (cmd.queue_rd_head) begin
        head <= head + kts_pkg::QUEUE_CW'(1);
      end
      if (cmd.queue_clr) begin
        tail <= '0;
      end else if (queue_we) begin
        tail <= tail + kts_pkg::QUEUE_CW'(1);
      end
      if (cmd.out_load_order || cmd.out_load_cycle) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.u_load) begin
      u <= queue_q;
    end
    if (cmd.out_load_order) begin
      vertex    <= queue_q;
      last      <= status.i_last;
      has_cycle <= 1'b0;
    end else if (cmd.out_load_cycle) begin
      vertex    <= '0;
      last      <= 1'b1;
      has_cycle <= 1'b1;
    end
  end

  always_comb begin
    status.i_lt_n       = i < n;
    status.i_last       = (i + kts_pkg::COUNT_W'(1)) == n;
    status.e_lt_total   = e < total;
    status.edge_ok      = (kts_pkg::COUNT_W'(edge_q.src) < n) && edge_dst_in;
    status.edge_match   = (edge_q.src == u) && edge_dst_in;
    status.head_lt_tail = head < tail;
    status.tail_eq_n    = kts_pkg::COUNT_W'(tail) == n;
    status.n_zero       = n == '0;
    status.out_free     = !out_valid || out_ready;
  end

endmodule

>>> hw/rtl/kts_ctrl.sv
// ----------------------------------------------------------------------------
// kts_ctrl
// Sequencer for edge loading and the sort passes: clear, count, seed,
// release, and result emission.
// ----------------------------------------------------------------------------
module kts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_cmd,
  output logic                 req_ready,
  output kts_pkg::dp_cmd_t     cmd,
  input  kts_pkg::dp_status_t  status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CNT_RD,
    S_CNT_EDGE,
    S_CNT_WR,
    S_SEED_RD,
    S_SEED_CHK,
    S_DEQ,
    S_DEQ_WAIT,
    S_REL_RD,
    S_REL_EDGE,
    S_REL_DEC,
    S_FINISH,
    S_OUT_RD,
    S_OUT_LOAD,
    S_OUT_CYCLE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_cmd == kts_pkg::CMD_LOAD) begin
            cmd.load_edge = 1'b1;
          end else begin
            cmd.i_clr     = 1'b1;
            cmd.queue_clr = 1'b1;
            state_next    = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        if (status.i_lt_n) begin
          cmd.deg_zero_wr = 1'b1;
          cmd.i_inc       = 1'b1;
        end else begin
          cmd.e_clr  = 1'b1;
          state_next = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        if (status.e_lt_total) begin
          cmd.edge_rd = 1'b1;
          state_next  = S_CNT_EDGE;
        end else begin
          cmd.i_clr  = 1'b1;
          state_next = S_SEED_RD;
        end
      end
      S_CNT_EDGE: begin
        if (status.edge_ok) begin
          cmd.deg_rd_dst = 1'b1;
          state_next     = S_CNT_WR;
        end else begin
          cmd.e_inc  = 1'b1;
          state_next = S_CNT_RD;
        end
      end
      S_CNT_WR: begin
        cmd.deg_inc_wr = 1'b1;
        cmd.e_inc      = 1'b1;
        state_next     = S_CNT_RD;
      end
      S_SEED_RD: begin
        if (status.i_lt_n) begin
          cmd.deg_rd_i = 1'b1;
          state_next   = S_SEED_CHK;
        end else begin
          state_next = S_DEQ;
        end
      end
      S_SEED_CHK: begin
        cmd.queue_push_i = 1'b1;
        cmd.i_inc        = 1'b1;
        state_next       = S_SEED_RD;
      end
      S_DEQ: begin
        if (status.head_lt_tail) begin
          cmd.queue_rd_head = 1'b1;
          state_next        = S_DEQ_WAIT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DEQ_WAIT: begin
        cmd.u_load = 1'b1;
        cmd.e_clr  = 1'b1;
        state_next = S_REL_RD;
      end
      S_REL_RD: begin
        if (status.e_lt_total) begin
          cmd.edge_rd = 1'b1;
          state_next  = S_REL_EDGE;
        end else begin
          state_next = S_DEQ;
        end
      end
      S_REL_EDGE: begin
        if (status.edge_match) begin
          cmd.deg_rd_dst = 1'b1;
          state_next     = S_REL_DEC;
        end else begin
          cmd.e_inc  = 1'b1;
          state_next = S_REL_RD;
        end
      end
      S_REL_DEC: begin
        cmd.deg_dec = 1'b1;
        cmd.e_inc   = 1'b1;
        state_next  = S_REL_RD;
      end
      S_FINISH: begin
        cmd.total_clr = 1'b1;
        cmd.i_clr     = 1'b1;
        if (status.n_zero) begin
          state_next = S_IDLE;
        end else if (!status.tail_eq_n) begin
          state_next = S_OUT_CYCLE;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        cmd.queue_rd_i = 1'b1;
        state_next     = S_OUT_LOAD;
      end
      S_OUT_LOAD: begin
        if (status.out_free) begin
          cmd.out_load_order = 1'b1;
          cmd.i_inc          = 1'b1;
          state_next         = status.i_last ? S_IDLE : S_OUT_RD;
        end
      end
      S_OUT_CYCLE: begin
        if (status.out_free) begin
          cmd.out_load_cycle = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/kahn_topological_sort_unit.sv
// Load items are accepted back to back while idle. A start item clears the in-degrees,
// counts them over the stored in-range edges, seeds the queue with zero in-degree
// vertices and rescans the edge store per dequeued vertex to release successors. Then
// each ordered vertex, or else the cycle result, is loaded into the output register.
// Synchronous reset clears the controller, edge count, queue pointers and output
// valid, and sets vertex_count to 1; memories are not cleared.
// ----------------------------------------------------------------------------
// kahn_topological_sort_unit
// Topological sort engine: edge loading, Kahn sort sequencing and ordered
// vertex output.
// ----------------------------------------------------------------------------
module kahn_topological_sort_unit (
  input  logic        clk,
  input  logic        rst,
  kts_req_if.sink     request,
  kts_res_if.source   result,
  kts_cfg_if.sink     cfg
);

  kts_pkg::dp_cmd_t     dp_cmd;
  kts_pkg::dp_status_t  dp_status;

  assign cfg.ready = 1'b1;

  kts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_cmd   (request.cmd),
    .req_ready (request.ready),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  kts_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.vertex_count),
    .edge_source (request.edge_source),
    .edge_dest   (request.edge_dest),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .vertex      (result.vertex),
    .last        (result.last),
    .has_cycle   (result.has_cycle)
  );

`ifndef SYNTHESIS
  a_cycle_shape: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.has_cycle) |-> (result.last && (result.vertex == '0)))
    else $error("cycle result without last or with nonzero vertex");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready && (request.cmd == kts_pkg::CMD_START))
      |=> !request.ready)
    else $error("request ready right after a start transfer");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready && (request.cmd == kts_pkg::CMD_LOAD) &&
     !result.valid) |=> !result.valid)
    else $error("load transfer produced a result");
`endif

endmodule
